[rtl/core/pgr_pkg.sv]
// ----------------------------------------------------------------------------
// pgr_pkg
// Types and constants shared by the glyph run decoder core.
// ----------------------------------------------------------------------------
package pgr_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_glyph;
   } req_type;

   typedef struct packed {
      logic        run_value;
      logic [31:0] run_length;
      logic [15:0] repeat_rows;
      logic        glyph_done;
      logic        status;
      logic        last_of_item;
   } rsp_type;

   // byte as classified by the front end
   typedef struct packed {
      req_type req;
      logic    raw;
   } job_type;

   // register values, width and height already forced to at least one
   typedef struct packed {
      logic [3:0]  dyn_f;
      logic        start_black;
      logic [15:0] width;
      logic [15:0] height;
   } cfg_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ZEROS,
      PH_LONG,
      PH_SECOND
   } phase_type;

   typedef enum logic [2:0] {
      ST_FETCH,
      ST_UNIT,
      ST_ACC,
      ST_DIV,
      ST_ROWS,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      REG_DYN_F       = 2'd0,
      REG_START_BLACK = 2'd1,
      REG_WIDTH       = 2'd2,
      REG_HEIGHT      = 2'd3
   } reg_type;

   localparam logic [3:0]  MARK_REPEAT = 4'd14;
   localparam logic [3:0]  MARK_ONE    = 4'd15;
   localparam logic [3:0]  LAST_SHORT  = 4'd13;
   localparam logic [3:0]  RAW_DYN     = 4'd14;
   localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
   localparam logic [15:0] SAT16       = 16'hFFFF;

endpackage

[rtl/core/pgr_front.sv]
// ----------------------------------------------------------------------------
// pgr_front
// Input side: takes bytes, tags raw mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pgr_front
   import pgr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  req_type    req_data,
   output logic       req_full,
   input  logic [3:0] dyn_f,
   output logic       job_valid,
   output job_type    job,
   input  logic       job_pop
);

   job_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;
   logic       pop_ok;

   assign req_full  = (cnt_ff == 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = slot_ff[rd_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = job_pop && job_valid;

   always_comb begin
      wr_in  = push_ok ? ~wr_ff : wr_ff;
      rd_in  = pop_ok ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ff] <= '{req: req_data, raw: (dyn_f >= RAW_DYN)};
      end
   end

endmodule

[rtl/core/pgr_rsp_queue.sv]
// ----------------------------------------------------------------------------
// pgr_rsp_queue
// Result queue between the decode engine and the result port.
// ----------------------------------------------------------------------------
module pgr_rsp_queue
   import pgr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output rsp_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   rsp_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            push_ok;
   logic            pop_ok;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;

   always_comb begin
      wr_in  = push_ok ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop_ok ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CW'(push_ok) - CW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/pgr_back.sv]
// ----------------------------------------------------------------------------
// pgr_back
// Decode engine: packed-number decoding, row accounting, result staging.
// ----------------------------------------------------------------------------
module pgr_back
   import pgr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    out_push,
   output rsp_type out_data,
   input  logic    out_full
);

   state_type   state_ff, state_in;
   logic [7:0]  byte_ff, byte_in;
   logic        raw_ff, raw_in;
   logic [3:0]  unit_ff, unit_in;
   logic        err_ff, err_in;
   phase_type   phase_ff, phase_in;
   logic [3:0]  zc_ff, zc_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] prep_ff, prep_in;
   logic        isrep_ff, isrep_in;
   logic        colour_ff, colour_in;
   logic [15:0] col_ff, col_in;
   logic [16:0] rows_ff, rows_in;
   logic [31:0] len_ff, len_in;
   logic        val_ff, val_in;
   logic [15:0] reps_ff, reps_in;
   logic        bad_ff, bad_in;
   logic [31:0] dq_ff, dq_in;
   logic [16:0] dr_ff, dr_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   rsp_type     pend_ff, pend_in;
   logic        pend_v_ff, pend_v_in;

   // nybble decoder
   logic [3:0]  nyb;
   logic [3:0]  d;
   phase_type   f_phase;
   logic [3:0]  f_zc;
   logic [31:0] f_acc;
   logic [15:0] f_prep;
   logic        f_isrep;
   logic        f_run;
   logic [31:0] f_len;
   logic        fin;
   logic [31:0] fin_num;
   logic [31:0] acc_sh;
   logic [3:0]  zc_dec;
   logic [33:0] v34;

   // row accounting
   logic        units_done;
   logic [31:0] rest;
   logic [16:0] used;
   logic [16:0] rows_sub;
   logic [16:0] rem_try;
   logic        q_bit;
   logic [16:0] rows_full;
   logic [31:0] rows_wide;

   assign d   = cfg.dyn_f;
   assign nyb = unit_ff[0] ? byte_ff[3:0] : byte_ff[7:4];

   always_comb begin
      f_phase = phase_ff;
      f_zc    = zc_ff;
      f_acc   = acc_ff;
      f_prep  = prep_ff;
      f_isrep = isrep_ff;
      f_run   = 1'b0;
      f_len   = '0;
      fin     = 1'b0;
      fin_num = '0;
      acc_sh  = (acc_ff > 32'h0FFF_FFFF) ? SAT32 : {acc_ff[27:0], nyb};
      zc_dec  = zc_ff - 4'd1;
      v34     = {2'b00, acc_sh} + 34'd193 + 34'(d) - (34'(d) << 4);
      unique case (phase_ff)
         PH_ZEROS: begin
            if (nyb == 4'd0) begin
               if (zc_ff != 4'd15) f_zc = zc_ff + 4'd1;
            end else begin
               f_acc   = {28'd0, nyb};
               f_phase = PH_LONG;
            end
         end
         PH_LONG: begin
            f_acc = acc_sh;
            f_zc  = zc_dec;
            if (zc_dec == 4'd0) begin
               fin     = 1'b1;
               fin_num = v34[32] ? SAT32 : v34[31:0];
            end
         end
         PH_SECOND: begin
            fin     = 1'b1;
            fin_num = ((acc_ff - 32'(d) - 32'd1) << 4) + 32'(nyb) + 32'(d) + 32'd1;
         end
         default: begin
            f_phase = PH_IDLE;
            priority if (nyb == 4'd0) begin
               f_phase = PH_ZEROS;
               f_zc    = 4'd1;
            end else if (nyb <= d) begin
               fin     = 1'b1;
               fin_num = 32'(nyb);
            end else if (nyb <= LAST_SHORT) begin
               f_acc   = 32'(nyb);
               f_phase = PH_SECOND;
            end else if (nyb == MARK_REPEAT) begin
               f_isrep = 1'b1;
            end else begin
               f_prep  = 16'd1;
               f_isrep = 1'b0;
            end
         end
      endcase
      if (fin) begin
         f_phase = PH_IDLE;
         f_acc   = '0;
         f_zc    = '0;
         if (isrep_ff) begin
            f_prep  = (fin_num > 32'(SAT16)) ? SAT16 : fin_num[15:0];
            f_isrep = 1'b0;
         end else begin
            f_run = 1'b1;
            f_len = fin_num;
         end
      end
   end

   assign units_done = raw_ff ? (unit_ff == 4'd8) : (unit_ff == 4'd2);
   assign rest       = len_ff - 32'(col_ff);
   assign used       = {1'b0, prep_ff} + 17'd1;
   assign rows_sub   = rows_ff - used;
   assign rem_try    = {dr_ff[15:0], dq_ff[31]};
   assign q_bit      = (rem_try >= {1'b0, cfg.width});
   assign rows_wide  = 32'(rows_ff);
   assign rows_full  = rows_ff - dq_ff[16:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FETCH: if (job_valid) state_in = ST_UNIT;
         ST_UNIT: begin
            priority if (err_ff) begin
               if (!out_full) state_in = ST_FETCH;
            end else if (rows_ff == '0 || units_done) begin
               state_in = ST_FLUSH;
            end else if (raw_ff || f_run) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            priority if (len_ff < 32'(col_ff)) state_in = ST_EMIT;
            else if (used > rows_ff || rest == '0) state_in = ST_EMIT;
            else if (rest < 32'(cfg.width)) state_in = ST_ROWS;
            else state_in = ST_DIV;
         end
         ST_DIV:  if (dcnt_ff == 5'd31) state_in = ST_ROWS;
         ST_ROWS: state_in = ST_EMIT;
         ST_EMIT: if (!(pend_v_ff && out_full)) state_in = ST_UNIT;
         ST_FLUSH: if (!(pend_v_ff && out_full)) state_in = ST_FETCH;
         default: state_in = ST_FETCH;
      endcase
   end

   // datapath and outputs
   always_comb begin
      byte_in   = byte_ff;
      raw_in    = raw_ff;
      unit_in   = unit_ff;
      err_in    = err_ff;
      phase_in  = phase_ff;
      zc_in     = zc_ff;
      acc_in    = acc_ff;
      prep_in   = prep_ff;
      isrep_in  = isrep_ff;
      colour_in = colour_ff;
      col_in    = col_ff;
      rows_in   = rows_ff;
      len_in    = len_ff;
      val_in    = val_ff;
      reps_in   = reps_ff;
      bad_in    = bad_ff;
      dq_in     = dq_ff;
      dr_in     = dr_ff;
      dcnt_in   = dcnt_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      job_pop   = 1'b0;
      out_push  = 1'b0;
      out_data  = pend_ff;
      unique case (state_ff)
         ST_FETCH: begin
            if (job_valid) begin
               job_pop = 1'b1;
               byte_in = job.req.data_byte;
               raw_in  = job.raw;
               unit_in = '0;
               if (job.req.first_of_glyph) begin
                  phase_in  = PH_IDLE;
                  zc_in     = '0;
                  acc_in    = '0;
                  prep_in   = '0;
                  isrep_in  = 1'b0;
                  colour_in = cfg.start_black;
                  col_in    = cfg.width;
                  rows_in   = {1'b0, cfg.height};
                  err_in    = 1'b0;
               end else begin
                  err_in = (rows_ff == '0);
               end
            end
         end
         ST_UNIT: begin
            priority if (err_ff) begin
               out_data = '{run_value: 1'b0, run_length: '0, repeat_rows: '0,
                            glyph_done: 1'b1, status: 1'b1, last_of_item: 1'b1};
               if (!out_full) begin
                  out_push = 1'b1;
                  err_in   = 1'b0;
               end
            end else if (rows_ff == '0 || units_done) begin
               // nothing
            end else if (raw_ff) begin
               len_in  = 32'd1;
               val_in  = byte_ff[3'd7 - unit_ff[2:0]];
               unit_in = unit_ff + 4'd1;
            end else begin
               phase_in = f_phase;
               zc_in    = f_zc;
               acc_in   = f_acc;
               prep_in  = f_prep;
               isrep_in = f_isrep;
               unit_in  = unit_ff + 4'd1;
               if (f_run) begin
                  len_in    = f_len;
                  val_in    = colour_ff;
                  colour_in = ~colour_ff;
               end
            end
         end
         ST_ACC: begin
            reps_in = '0;
            bad_in  = 1'b0;
            if (len_ff < 32'(col_ff)) begin
               col_in = col_ff - len_ff[15:0];
            end else begin
               reps_in = prep_ff;
               prep_in = '0;
               col_in  = cfg.width;
               if (used > rows_ff) begin
                  bad_in  = 1'b1;
                  rows_in = '0;
               end else begin
                  rows_in = rows_sub;
               end
               if (rest < 32'(cfg.width)) begin
                  dq_in = '0;
                  dr_in = 17'(rest[15:0]);
               end else begin
                  dq_in = rest;
                  dr_in = '0;
               end
               dcnt_in = '0;
            end
         end
         ST_DIV: begin
            dr_in   = q_bit ? rem_try - {1'b0, cfg.width} : rem_try;
            dq_in   = {dq_ff[30:0], q_bit};
            dcnt_in = dcnt_ff + 5'd1;
         end
         ST_ROWS: begin
            if (dq_ff > rows_wide) begin
               bad_in  = 1'b1;
               rows_in = '0;
               col_in  = cfg.width;
            end else if (dr_ff[15:0] != '0 && rows_full == '0) begin
               bad_in  = 1'b1;
               rows_in = '0;
               col_in  = cfg.width;
            end else begin
               rows_in = rows_full;
               if (dr_ff[15:0] != '0) col_in = cfg.width - dr_ff[15:0];
            end
         end
         ST_EMIT: begin
            out_data.last_of_item = 1'b0;
            if (!(pend_v_ff && out_full)) begin
               out_push  = pend_v_ff;
               pend_v_in = 1'b1;
               pend_in   = '{run_value: val_ff, run_length: len_ff, repeat_rows: reps_ff,
                             glyph_done: (rows_ff == '0), status: bad_ff,
                             last_of_item: 1'b0};
            end
         end
         ST_FLUSH: begin
            out_data.last_of_item = 1'b1;
            if (pend_v_ff && !out_full) begin
               out_push  = 1'b1;
               pend_v_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FETCH;
         err_ff    <= 1'b0;
         pend_v_ff <= 1'b0;
         phase_ff  <= PH_IDLE;
         zc_ff     <= '0;
         acc_ff    <= '0;
         prep_ff   <= '0;
         isrep_ff  <= 1'b0;
         colour_ff <= 1'b0;
         col_ff    <= '0;
         rows_ff   <= '0;
         unit_ff   <= '0;
         dcnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         err_ff    <= err_in;
         pend_v_ff <= pend_v_in;
         phase_ff  <= phase_in;
         zc_ff     <= zc_in;
         acc_ff    <= acc_in;
         prep_ff   <= prep_in;
         isrep_ff  <= isrep_in;
         colour_ff <= colour_in;
         col_ff    <= col_in;
         rows_ff   <= rows_in;
         unit_ff   <= unit_in;
         dcnt_ff   <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      raw_ff  <= raw_in;
      len_ff  <= len_in;
      val_ff  <= val_in;
      reps_ff <= reps_in;
      bad_ff  <= bad_in;
      dq_ff   <= dq_in;
      dr_ff   <= dr_in;
      pend_ff <= pend_in;
   end

endmodule

[rtl/core/pk_glyph_run_decoder_core.sv]
// ----------------------------------------------------------------------------
// pk_glyph_run_decoder_core
// Packed run-length decoder for one glyph: bytes in, colour runs out.
// ----------------------------------------------------------------------------
//  channel   direction  ports                     transaction
//  req       in         req_push / req_full       one packed bitmap byte
//  rsp       out        rsp_pop / rsp_empty       one colour run
//  csr       in         APB psel/penable/pwrite   register write or read
//
//  A byte is fetched, then decoded one nybble (or one bit in raw mode) at a time
//  and closed out; a byte with no glyph open yields a single error result.
//  Each run then goes through row accounting; a run spilling over a full row
//  also passes through the shared bit-serial divider.
//  Reset is synchronous and clears control state and the decode state.
//  The front queue (2 bytes) and result queue (RSP_DEPTH) let each side stall
//  independently; the engine holds back one result so it can mark the last one.
// ----------------------------------------------------------------------------
module pk_glyph_run_decoder_core
   import pgr_pkg::*;
#(
   parameter int RSP_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [3:0]  dyn_f_ff;
   logic        start_black_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic        csr_wr;
   reg_type     csr_reg;
   cfg_type     cfg;
   logic        job_valid;
   job_type     job;
   logic        job_pop;
   logic        out_push;
   rsp_type     out_data;
   logic        out_full;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dyn_f_ff       <= 4'd0;
         start_black_ff <= 1'b0;
         width_ff       <= 16'd1;
         height_ff      <= 16'd1;
      end else if (csr_wr) begin
         unique case (csr_reg)
            REG_DYN_F:       dyn_f_ff       <= csr_pwdata[3:0];
            REG_START_BLACK: start_black_ff <= csr_pwdata[0];
            REG_WIDTH:       width_ff       <= csr_pwdata[15:0];
            REG_HEIGHT:      height_ff      <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_DYN_F:       csr_prdata = {28'd0, dyn_f_ff};
         REG_START_BLACK: csr_prdata = {31'd0, start_black_ff};
         REG_WIDTH:       csr_prdata = {16'd0, width_ff};
         REG_HEIGHT:      csr_prdata = {16'd0, height_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // zero size is taken as one
   assign cfg = '{dyn_f:       dyn_f_ff,
                  start_black: start_black_ff,
                  width:       (width_ff == '0) ? 16'd1 : width_ff,
                  height:      (height_ff == '0) ? 16'd1 : height_ff};

   pgr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .dyn_f     (dyn_f_ff),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   pgr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .out_push  (out_push),
      .out_data  (out_data),
      .out_full  (out_full)
   );

   pgr_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (rsp_data)
   );

endmodule

[dv/tb_pk_glyph_run_decoder_core.sv]
// ----------------------------------------------------------------------------
// tb_pk_glyph_run_decoder_core
// Self-checking bench for the glyph run decoder: packed bytes are pushed in
// and every colour run is checked field by field against a built-in
// predictor. The bench steps through several register settings (raw and
// packed modes, extreme sizes) and uses random idling and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pk_glyph_run_decoder_core;
   import pgr_pkg::*;

   localparam int SETTLE_CYCLES = 400;   // covers the divider on several runs
   localparam int QUIET_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   req_type     req_data = '0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pk_glyph_run_decoder_core dut (.*);

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // register mirror and decoder state of the predictor
   // ---------------------------------------------------------------------
   logic [3:0]  cfg_dyn = '0;
   logic        cfg_black = 1'b0;
   logic [15:0] cfg_width = 16'd1;
   logic [15:0] cfg_height = 16'd1;

   phase_type   ph = PH_IDLE;
   logic [3:0]  zero_cnt = '0;
   logic [31:0] num_acc = '0;
   logic [15:0] rep_pending = '0;
   bit          num_is_rep = 1'b0;
   bit          colour = 1'b0;
   longint      col_left = 0;
   longint      rows_left = 0;

   rsp_type     expected_runs[$];   // runs still owed by the block
   rsp_type     byte_runs[$];       // runs of the byte being predicted
   req_type     byte_q[$];          // bytes waiting for the driver
   logic [3:0]  nyb_q[$];           // nybbles of the glyph being built

   int          errors = 0;
   int          bytes_in = 0;
   int          runs_out = 0;
   int          tx_idle = 36;
   int          rx_idle = 36;
   bit          hold_req = 1'b0;
   int          hold_left = 0;
   int          quiet = 0;

   task automatic report(input string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // row bookkeeping for one run
   function automatic void account_run(bit val, logic [31:0] len);
      longint w, rest, full, rem, used, l;
      bit bad;
      logic [15:0] reps;
      rsp_type r;
      w = (cfg_width == 0) ? 1 : cfg_width;
      l = len;
      reps = '0;
      bad = 1'b0;
      if (l < col_left) begin
         col_left -= l;
      end else begin
         rest = l - col_left;
         used = rep_pending + 1;
         reps = rep_pending;
         rep_pending = '0;
         col_left = w;
         if (used > rows_left) begin
            bad = 1'b1;
            rows_left = 0;
         end else begin
            rows_left -= used;
         end
         if (!bad && rest > 0) begin
            full = rest / w;
            rem = rest % w;
            if (full > rows_left) begin
               bad = 1'b1;
            end else begin
               rows_left -= full;
               if (rem > 0) begin
                  if (rows_left == 0) bad = 1'b1;
                  else col_left = w - rem;
               end
            end
         end
         if (bad) begin
            rows_left = 0;
            col_left = w;
         end
      end
      r.run_value = val;
      r.run_length = len;
      r.repeat_rows = reps;
      r.glyph_done = (rows_left == 0);
      r.status = bad;
      r.last_of_item = 1'b0;
      byte_runs.push_back(r);
   endfunction

   // close a packed number: a repeat count is stored, anything else is a run
   function automatic bit close_number(logic [31:0] v);
      ph = PH_IDLE;
      num_acc = '0;
      zero_cnt = '0;
      if (num_is_rep) begin
         rep_pending = (v > 32'h0000_FFFF) ? SAT16 : v[15:0];
         num_is_rep = 1'b0;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit decode_nybble(logic [3:0] n, output logic [31:0] len);
      longint v, d;
      d = longint'(cfg_dyn);
      len = '0;
      case (ph)
         PH_ZEROS: begin
            if (n == 0) begin
               if (zero_cnt < 4'd15) zero_cnt++;
            end else begin
               num_acc = 32'(n);
               ph = PH_LONG;
            end
            return 1'b0;
         end
         PH_LONG: begin
            if (num_acc > 32'h0FFF_FFFF) num_acc = SAT32;
            else num_acc = num_acc * 16 + 32'(n);
            zero_cnt--;
            if (zero_cnt != 0) return 1'b0;
            v = longint'(num_acc) + (13 - d) * 16 + d - 15;
            len = (v > longint'(SAT32)) ? SAT32 : v[31:0];
            return close_number(len);
         end
         PH_SECOND: begin
            len = (num_acc - 32'(cfg_dyn) - 32'd1) * 32'd16 + 32'(n) + 32'(cfg_dyn) + 32'd1;
            return close_number(len);
         end
         default: begin
            ph = PH_IDLE;
            if (n == 0) begin
               ph = PH_ZEROS;
               zero_cnt = 4'd1;
               return 1'b0;
            end
            if (n <= cfg_dyn) begin
               len = 32'(n);
               return close_number(len);
            end
            if (n <= LAST_SHORT) begin
               num_acc = 32'(n);
               ph = PH_SECOND;
               return 1'b0;
            end
            if (n == MARK_REPEAT) begin
               num_is_rep = 1'b1;
               return 1'b0;
            end
            rep_pending = 16'd1;   // MARK_ONE
            num_is_rep = 1'b0;
            return 1'b0;
         end
      endcase
   endfunction

   // expected runs for one accepted byte
   function automatic void predict_byte(req_type q);
      logic [31:0] len;
      logic [3:0] nyb;
      rsp_type r;
      byte_runs.delete();
      if (q.first_of_glyph) begin
         ph = PH_IDLE;
         zero_cnt = '0;
         num_acc = '0;
         rep_pending = '0;
         num_is_rep = 1'b0;
         colour = cfg_black;
         col_left = (cfg_width == 0) ? 1 : cfg_width;
         rows_left = (cfg_height == 0) ? 1 : cfg_height;
      end
      if (rows_left == 0) begin
         // no glyph in progress
         r = '0;
         r.glyph_done = 1'b1;
         r.status = 1'b1;
         byte_runs.push_back(r);
      end else if (cfg_dyn >= RAW_DYN) begin
         for (int b = 7; b >= 0 && rows_left != 0; b--) account_run(q.data_byte[b], 32'd1);
      end else begin
         for (int h = 0; h < 2 && rows_left != 0; h++) begin
            nyb = (h == 0) ? q.data_byte[7:4] : q.data_byte[3:0];
            if (decode_nybble(nyb, len)) begin
               account_run(colour, len);
               colour ^= 1'b1;
            end
         end
      end
      if (byte_runs.size() > 0) begin
         r = byte_runs.pop_back();
         r.last_of_item = 1'b1;
         byte_runs.push_back(r);
      end
      foreach (byte_runs[i]) expected_runs.push_back(byte_runs[i]);
   endfunction

   // ---------------------------------------------------------------------
   // driver: push side
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_byte(req_data);
            bytes_in++;
         end
         if (!req_push || !req_full) begin
            if (byte_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
               req_data <= byte_q.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: pop side, with an optional long hold-off
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            runs_out++;
            if (expected_runs.size() == 0) begin
               report("run transaction with nothing expected");
            end else begin
               want = expected_runs.pop_front();
               if (rsp_data.run_value !== want.run_value)
                  report($sformatf("run_value %0b, expected %0b",
                                   rsp_data.run_value, want.run_value));
               if (rsp_data.run_length !== want.run_length)
                  report($sformatf("run_length %0d, expected %0d",
                                   rsp_data.run_length, want.run_length));
               if (rsp_data.repeat_rows !== want.repeat_rows)
                  report($sformatf("repeat_rows %0d, expected %0d",
                                   rsp_data.repeat_rows, want.repeat_rows));
               if (rsp_data.glyph_done !== want.glyph_done)
                  report($sformatf("glyph_done %0b, expected %0b",
                                   rsp_data.glyph_done, want.glyph_done));
               if (rsp_data.status !== want.status)
                  report($sformatf("status %0b, expected %0b",
                                   rsp_data.status, want.status));
               if (rsp_data.last_of_item !== want.last_of_item)
                  report($sformatf("last_of_item %0b, expected %0b",
                                   rsp_data.last_of_item, want.last_of_item));
            end
         end
         if (hold_req) begin
            hold_req <= 1'b0;
            hold_left <= HOLD_CYCLES;
            rsp_pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= rx_idle);
         end
      end
   end

   // watchdog: any stretch with no transaction at all
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_psel || reset)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("tb: watchdog expired, %0d runs outstanding", expected_runs.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic csr_access(input reg_type idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== val)
         report($sformatf("register %s read %0h, wrote %0h", idx.name(), csr_prdata, val));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // block idle: queues drained plus slack for runs still in the engine;
   // sampled on the falling edge so the driver's updates have landed
   task automatic wait_idle();
      @(negedge clock);
      while (byte_q.size() > 0 || req_push || expected_runs.size() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_setting(input int dyn, input bit blk, input int w, input int h);
      wait_idle();
      csr_access(REG_DYN_F, 32'(dyn));
      csr_access(REG_START_BLACK, {31'd0, blk});
      csr_access(REG_WIDTH, 32'(w));
      csr_access(REG_HEIGHT, 32'(h));
      cfg_dyn = 4'(dyn);
      cfg_black = blk;
      cfg_width = 16'(w);
      cfg_height = 16'(h);
   endtask

   // packs nyb_q high nybble first; the first byte restarts the glyph
   function automatic int pack_glyph();
      req_type q;
      int n;
      n = 0;
      if (nyb_q.size() % 2) nyb_q.push_back(4'd0);
      while (nyb_q.size() > 0) begin
         q.data_byte[7:4] = nyb_q.pop_front();
         q.data_byte[3:0] = nyb_q.pop_front();
         q.first_of_glyph = (n == 0);
         byte_q.push_back(q);
         n++;
      end
      return n;
   endfunction

   // one packed number in the current dyn_f, optionally a repeat marker
   task automatic add_number(input bit markers);
      int kind, z;
      kind = $urandom_range(0, 9);
      if (markers && kind == 9) begin
         nyb_q.push_back(MARK_ONE);
      end else if (markers && kind == 8) begin
         nyb_q.push_back(MARK_REPEAT);
         add_number(1'b0);
      end else if (kind <= 4 && cfg_dyn >= 1) begin
         nyb_q.push_back(4'($urandom_range(1, cfg_dyn)));
      end else if (kind <= 6 && cfg_dyn < LAST_SHORT) begin
         nyb_q.push_back(4'($urandom_range(cfg_dyn + 1, 13)));
         nyb_q.push_back(4'($urandom_range(0, 15)));
      end else begin
         z = $urandom_range(1, 3);
         repeat (z) nyb_q.push_back(4'd0);
         nyb_q.push_back(4'($urandom_range(1, 15)));
         repeat (z) nyb_q.push_back(4'($urandom_range(0, 15)));
      end
   endtask

   // mostly well-formed glyphs, some noise bytes; raw mode is all random;
   // a glyph is cut short so that exactly count bytes are queued
   task automatic random_bytes(input int count);
      int made;
      req_type q;
      made = 0;
      while (made < count) begin
         if (cfg_dyn >= RAW_DYN || $urandom_range(99) < 15) begin
            q.data_byte = 8'($urandom_range(0, 255));
            q.first_of_glyph = ($urandom_range(0, 3) == 0);
            byte_q.push_back(q);
            made++;
         end else begin
            repeat ($urandom_range(3, 12)) add_number(1'b1);
            while (nyb_q.size() > 2 * (count - made)) void'(nyb_q.pop_back());
            made += pack_glyph();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      req_type q;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a byte straight after reset, no glyph open
      q.data_byte = 8'hA5;
      q.first_of_glyph = 1'b0;
      byte_q.push_back(q);

      // directed glyph, wide and tall: every number form, markers,
      // big repeat, saturated long run, overrun, padding after the end
      load_setting(9, 1, 65535, 65535);
      nyb_q = '{4'd1, 4'd9, 4'd10, 4'd0, 4'd13, 4'd15,
                MARK_REPEAT, MARK_REPEAT, MARK_ONE,
                MARK_REPEAT, 4'd0, 4'd0, 4'd15, 4'd15, 4'd15,
                MARK_REPEAT, 4'd0, 4'd0, 4'd0, 4'd0,
                4'd15, 4'd15, 4'd15, 4'd15, 4'd15};
      repeat (17) nyb_q.push_back(4'd0);    // zero count saturates
      nyb_q.push_back(4'd1);
      repeat (15) nyb_q.push_back(4'd15);   // value saturates at 32 bits
      repeat (3) nyb_q.push_back(4'd7);     // padding after the glyph
      void'(pack_glyph());
      q.data_byte = 8'hFF;
      q.first_of_glyph = 1'b0;
      byte_q.push_back(q);                  // byte after the end

      load_setting(0, 0, 5, 6);
      random_bytes(10);
      load_setting(13, 1, 1, 65535);
      random_bytes(9);
      load_setting(14, 1, 3, 4);            // raw bits
      random_bytes(8);
      load_setting(15, 0, 8, 2);            // fifteen behaves as raw
      random_bytes(6);
      load_setting(7, 1, 0, 0);             // zero sizes read as one
      random_bytes(6);

      // output held off while input keeps coming, so the block backs up
      load_setting(5, 0, 7, 9);
      hold_req = 1'b1;
      random_bytes(18);

      // no idling on either side
      load_setting(11, 1, 12, 20);
      tx_idle = 0;
      rx_idle = 0;
      random_bytes(12);
      wait_idle();
      tx_idle = 36;
      rx_idle = 36;
      load_setting(3, 0, 65535, 1);
      random_bytes(8);

      wait_idle();
      $display("tb: %0d bytes in, %0d runs checked over nine register settings",
               bytes_in, runs_out);
      $display("tb: raw and packed modes, markers, saturation, overruns, stalls");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatches", errors);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
